@@ sv/ssf_pkg.sv @@
// Shared types, constants and the BCD segment decode for the seven-segment scanner.
package ssf_pkg;

  localparam int MaxDigitsDef = 8;
  localparam int FlashShift = 1;
  localparam logic [7:0] DotMask = 8'h80;
  localparam logic [3:0] DigitCountRst = 4'd8;

  localparam logic [1:0] RegDigitCount = 2'd0;
  localparam logic [1:0] RegFlashFirst = 2'd1;
  localparam logic [1:0] RegFlashLast = 2'd2;
  localparam logic [1:0] RegFlashPeriod = 2'd3;

  typedef enum logic [1:0] {
    ModeClear  = 2'd0,
    ModeAppend = 2'd1,
    ModeTick   = 2'd2,
    ModeToggle = 2'd3
  } mode_e;

  typedef struct packed {
    logic clear;
    logic append;
    logic toggle;
  } store_cmd_t;

  function automatic logic [7:0] bcd_to_seg(input logic [3:0] v);
    logic [7:0] seg;
    case (v)
      4'd0: seg = 8'h3F;
      4'd1: seg = 8'h06;
      4'd2: seg = 8'h5B;
      4'd3: seg = 8'h4F;
      4'd4: seg = 8'h66;
      4'd5: seg = 8'h6D;
      4'd6: seg = 8'h7D;
      4'd7: seg = 8'h07;
      4'd8: seg = 8'h7F;
      4'd9: seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

@@ sv/ssf_store.sv @@
// Per-digit segment pattern store with clear, append and dot toggle.
module ssf_store #(
  parameter int MAX_DIGITS = ssf_pkg::MaxDigitsDef,
  parameter int AdW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ssf_pkg::store_cmd_t    cmd_i,
  input  logic [AdW-1:0]         wr_addr_i,
  input  logic [7:0]             wr_data_i,
  input  logic [2:0]             tog_first_i,
  input  logic [AdW-1:0]         tog_last_i,
  input  logic [AdW-1:0]         rd_addr_i,
  output logic [7:0]             rd_data_o
);

  logic [7:0] store_q [MAX_DIGITS];
  logic [7:0] store_d [MAX_DIGITS];

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      store_d[i] = store_q[i];
      if (cmd_i.clear) begin
        store_d[i] = 8'h00;
      end else if (cmd_i.append && (int'(wr_addr_i) == i)) begin
        store_d[i] = wr_data_i;
      end else if (cmd_i.toggle && (i >= int'(tog_first_i)) && (i <= int'(tog_last_i))) begin
        store_d[i] = store_q[i] ^ ssf_pkg::DotMask;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_DIGITS; i++) store_q[i] <= 8'h00;
    end else begin
      for (int i = 0; i < MAX_DIGITS; i++) store_q[i] <= store_d[i];
    end
  end

  assign rd_data_o = store_q[rd_addr_i];

endmodule

@@ sv/seven_segment_scan_with_flashing_unit.sv @@
// Seven-segment scanner top level: config port, scan pointer, flash counter, output register.
// Takes one word per clock (clear, append, tick or dot toggle in tuser); each tick word yields
// one output word in the next cycle, carrying the segment pattern and digit index, held in a
// single output register so the next word can be taken as the last result drains, and input
// stalls only when that register is full and not being drained. Configuration writes clear
// the flash counter and restart the scan so the next tick drives digit 0.
module seven_segment_scan_with_flashing_unit #(
  parameter int MAX_DIGITS = ssf_pkg::MaxDigitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // bcd_value[3:0], dot_first[6:4], dot_last[9:7], zero pad
  input  logic [1:0]  s_axis_tuser,  // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // segments[7:0], digit_select[10:8], zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AdW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int PosW = $clog2(MAX_DIGITS + 1);

  function automatic logic [AdW-1:0] eff_last(input logic [3:0] dc);
    int c;
    c = int'(dc);
    if (c == 0) c = 1;
    if (c > MAX_DIGITS) c = MAX_DIGITS;
    return AdW'(c - 1);
  endfunction

  logic [3:0]  digit_count_q;
  logic [2:0]  flash_first_q, flash_last_q;
  logic [15:0] flash_period_q;
  logic [AdW-1:0]  active_q, active_d;
  logic [15:0]     fc_q, fc_d;
  logic [PosW-1:0] wpos_q, wpos_d;
  logic            m_valid_q;
  logic [7:0]      seg_q, seg_d;
  logic [2:0]      sel_q;

  logic            s_acc, cfg_we;
  logic [1:0]      cfg_idx;
  logic [3:0]      dc_next;
  ssf_pkg::mode_e  mode;
  logic [3:0]      bcd;
  logic [2:0]      dot_first, dot_last;
  logic [AdW-1:0]  last_eff, tog_last;
  logic            can_append, is_tick;
  logic [15:0]     fc_inc;
  logic [7:0]      rd_seg;
  ssf_pkg::store_cmd_t cmd;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    case (cfg_idx)
      ssf_pkg::RegDigitCount:  prdata = {28'd0, digit_count_q};
      ssf_pkg::RegFlashFirst:  prdata = {29'd0, flash_first_q};
      ssf_pkg::RegFlashLast:   prdata = {29'd0, flash_last_q};
      ssf_pkg::RegFlashPeriod: prdata = {16'd0, flash_period_q};
      default:                 prdata = 32'd0;
    endcase
  end

  assign dc_next = (cfg_idx == ssf_pkg::RegDigitCount) ? pwdata[3:0] : digit_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q  <= ssf_pkg::DigitCountRst;
      flash_first_q  <= 3'd0;
      flash_last_q   <= 3'd0;
      flash_period_q <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        ssf_pkg::RegDigitCount:  digit_count_q  <= pwdata[3:0];
        ssf_pkg::RegFlashFirst:  flash_first_q  <= pwdata[2:0];
        ssf_pkg::RegFlashLast:   flash_last_q   <= pwdata[2:0];
        ssf_pkg::RegFlashPeriod: flash_period_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = ~m_valid_q | m_axis_tready;
  assign s_acc = s_axis_tvalid & s_axis_tready;
  assign mode = ssf_pkg::mode_e'(s_axis_tuser);
  assign bcd = s_axis_tdata[3:0];
  assign dot_first = s_axis_tdata[6:4];
  assign dot_last = s_axis_tdata[9:7];

  assign last_eff = eff_last(digit_count_q);
  assign tog_last = (int'(dot_last) > int'(last_eff)) ? last_eff : AdW'(dot_last);
  assign can_append = int'(wpos_q) <= int'(last_eff);
  assign is_tick = s_acc && (mode == ssf_pkg::ModeTick);

  assign cmd.clear  = s_acc && (mode == ssf_pkg::ModeClear);
  assign cmd.append = s_acc && (mode == ssf_pkg::ModeAppend) && can_append;
  assign cmd.toggle = s_acc && (mode == ssf_pkg::ModeToggle);

  ssf_store #(
    .MAX_DIGITS(MAX_DIGITS),
    .AdW       (AdW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .wr_addr_i  (wpos_q[AdW-1:0]),
    .wr_data_i  (ssf_pkg::bcd_to_seg(bcd)),
    .tog_first_i(dot_first),
    .tog_last_i (tog_last),
    .rd_addr_i  (active_d),
    .rd_data_o  (rd_seg)
  );

  // advance scan, bump flash counter on wrap, blank flashing digits
  assign active_d = (active_q >= last_eff) ? '0 : active_q + AdW'(1);
  assign fc_inc = fc_q + 16'd1;

  always_comb begin
    fc_d = fc_q;
    if (active_d == '0) begin
      fc_d = (fc_inc >= flash_period_q) ? 16'd0 : fc_inc;
    end
    seg_d = rd_seg;
    if ((flash_period_q != 16'd0) && (fc_d >= (flash_period_q >> ssf_pkg::FlashShift)) &&
        (int'(active_d) >= int'(flash_first_q)) && (int'(active_d) <= int'(flash_last_q))) begin
      seg_d = 8'h00;
    end
  end

  assign wpos_d = cmd.clear ? '0 : (cmd.append ? wpos_q + PosW'(1) : wpos_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= eff_last(ssf_pkg::DigitCountRst);
      fc_q     <= 16'd0;
      wpos_q   <= '0;
    end else if (cfg_we) begin
      active_q <= eff_last(dc_next);
      fc_q     <= 16'd0;
    end else begin
      wpos_q <= wpos_d;
      if (is_tick) begin
        active_q <= active_d;
        fc_q     <= fc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (is_tick) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_tick) begin
      seg_q <= seg_d;
      sel_q <= 3'(active_d);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata = {5'd0, sel_q, seg_q};

`ifndef SYNTHESIS
  a_active_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q <= eff_last(digit_count_q))
    else $error("scan pointer beyond digit count");

  a_wpos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(wpos_q) <= MAX_DIGITS)
    else $error("write position beyond store");

  a_flash_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fc_q == 16'd0) || (fc_q < flash_period_q))
    else $error("flash counter beyond period");

  a_out_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(is_tick))
    else $error("output word without tick");
`endif

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the seven-segment scanner with a local predictor.
module tb;

  typedef struct packed {
    ssf_pkg::mode_e mode;
    logic [3:0]     bcd;
    logic [2:0]     dot_first;
    logic [2:0]     dot_last;
  } disp_word_t;

  typedef struct packed {
    logic [7:0] segments;
    logic [2:0] digit_sel;
  } scan_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;  // bcd_value[3:0], dot_first[6:4], dot_last[9:7], zero pad
  logic [1:0]  s_axis_tuser;  // mode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;  // segments[7:0], digit_select[10:8], zero pad
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  seven_segment_scan_with_flashing_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // display model state
  logic [7:0]  seg_store [ssf_pkg::MaxDigitsDef];
  logic [2:0]  scan_pos;
  logic [15:0] flash_frames;
  logic [3:0]  write_pos;
  logic [3:0]  digits_reg;
  logic [2:0]  flash_lo_reg;
  logic [2:0]  flash_hi_reg;
  logic [15:0] flash_period_reg;

  disp_word_t word_q [$];
  scan_out_t  scan_q [$];
  int         pushed_cnt = 0;
  int         taken_cnt = 0;
  int         result_cnt = 0;
  int         fail_cnt = 0;
  int         settings_cnt = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic       word_taken = 1'b0;

  task automatic report(string msg);
    fail_cnt++;
    if (fail_cnt <= 40) $display("tb: mismatch at %0t ns: %s", $time, msg);
  endtask

  function automatic logic [7:0] bcd_pattern(logic [3:0] v);
    logic [7:0] p;
    case (v)
      4'd0: p = 8'h3F;
      4'd1: p = 8'h06;
      4'd2: p = 8'h5B;
      4'd3: p = 8'h4F;
      4'd4: p = 8'h66;
      4'd5: p = 8'h6D;
      4'd6: p = 8'h7D;
      4'd7: p = 8'h07;
      4'd8: p = 8'h7F;
      4'd9: p = 8'h6F;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  function automatic int unsigned live_digits();
    if (digits_reg == 4'd0) return 1;
    if (digits_reg > ssf_pkg::MaxDigitsDef) return ssf_pkg::MaxDigitsDef;
    return digits_reg;
  endfunction

  function automatic void display_reset();
    for (int i = 0; i < ssf_pkg::MaxDigitsDef; i++) seg_store[i] = 8'h00;
    digits_reg = ssf_pkg::DigitCountRst;
    flash_lo_reg = 3'd0;
    flash_hi_reg = 3'd0;
    flash_period_reg = 16'd0;
    flash_frames = 16'd0;
    write_pos = 4'd0;
    scan_pos = 3'(live_digits() - 1);
  endfunction

  function automatic void apply_word(disp_word_t w);
    int unsigned n;
    int unsigned top;
    int unsigned i;
    scan_out_t   r;
    n = live_digits();
    case (w.mode)
      ssf_pkg::ModeClear: begin
        for (i = 0; i < ssf_pkg::MaxDigitsDef; i++) seg_store[i] = 8'h00;
        write_pos = 4'd0;
      end
      ssf_pkg::ModeAppend: begin
        if (write_pos < n) begin
          seg_store[write_pos[2:0]] = bcd_pattern(w.bcd);
          write_pos++;
        end
      end
      ssf_pkg::ModeToggle: begin
        top = (w.dot_last > n - 1) ? n - 1 : w.dot_last;
        for (i = w.dot_first; i <= top; i++) seg_store[i] = seg_store[i] ^ ssf_pkg::DotMask;
      end
      default: begin
        if (scan_pos >= n - 1) scan_pos = 3'd0;
        else scan_pos = scan_pos + 3'd1;
        if (scan_pos == 3'd0) begin
          flash_frames = flash_frames + 16'd1;
          if (flash_frames >= flash_period_reg) flash_frames = 16'd0;
        end
        r.segments = seg_store[scan_pos];
        if (flash_period_reg != 16'd0 && flash_frames >= (flash_period_reg >> 1) &&
            scan_pos >= flash_lo_reg && scan_pos <= flash_hi_reg)
          r.segments = 8'h00;
        r.digit_sel = scan_pos;
        scan_q.push_back(r);
      end
    endcase
  endfunction

  // sender: hold a word until taken, then advance or idle
  always @(negedge clk_i) begin
    disp_word_t w;
    if (rst_ni && (!s_axis_tvalid || word_taken)) begin
      if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        w = word_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, w.dot_last, w.dot_first, w.bcd};
        s_axis_tuser <= w.mode;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    disp_word_t w;
    scan_out_t  e;
    word_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (word_taken) begin
      w.mode = ssf_pkg::mode_e'(s_axis_tuser);
      w.bcd = s_axis_tdata[3:0];
      w.dot_first = s_axis_tdata[6:4];
      w.dot_last = s_axis_tdata[9:7];
      taken_cnt++;
      apply_word(w);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_cnt++;
      if (scan_q.size() == 0) begin
        report($sformatf("result %h with none pending", m_axis_tdata));
      end else begin
        e = scan_q.pop_front();
        if (m_axis_tdata[7:0] !== e.segments)
          report($sformatf("segments %h, predicted %h (digit %0d)",
                           m_axis_tdata[7:0], e.segments, e.digit_sel));
        if (m_axis_tdata[10:8] !== e.digit_sel)
          report($sformatf("digit_select %0d, predicted %0d",
                           m_axis_tdata[10:8], e.digit_sel));
      end
    end
  end

  task automatic push_word(ssf_pkg::mode_e m, logic [3:0] b, logic [2:0] f, logic [2:0] l);
    disp_word_t w;
    w.mode = m;
    w.bcd = b;
    w.dot_first = f;
    w.dot_last = l;
    word_q.push_back(w);
    pushed_cnt++;
  endtask

  task automatic wait_drained();
    while (taken_cnt != pushed_cnt || scan_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      ssf_pkg::RegDigitCount: digits_reg = value[3:0];
      ssf_pkg::RegFlashFirst: flash_lo_reg = value[2:0];
      ssf_pkg::RegFlashLast: flash_hi_reg = value[2:0];
      default: flash_period_reg = value[15:0];
    endcase
    flash_frames = 16'd0;
    scan_pos = 3'(live_digits() - 1);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_phase(logic [3:0] cnt, logic [2:0] lo, logic [2:0] hi,
                           logic [15:0] per, int sp, int rp, int nwords);
    logic [31:0]    wd;
    int             pick;
    ssf_pkg::mode_e m;
    wd = $urandom();
    wd[3:0] = cnt;
    reg_write(ssf_pkg::RegDigitCount, wd);
    wd = $urandom();
    wd[2:0] = lo;
    reg_write(ssf_pkg::RegFlashFirst, wd);
    wd = $urandom();
    wd[2:0] = hi;
    reg_write(ssf_pkg::RegFlashLast, wd);
    wd = $urandom();
    wd[15:0] = per;
    reg_write(ssf_pkg::RegFlashPeriod, wd);
    settings_cnt++;
    send_idle_pct = sp;
    recv_stall_pct = rp;
    for (int k = 0; k < nwords; k++) begin
      pick = $urandom_range(99);
      if (pick < 7) m = ssf_pkg::ModeClear;
      else if (pick < 32) m = ssf_pkg::ModeAppend;
      else if (pick < 82) m = ssf_pkg::ModeTick;
      else m = ssf_pkg::ModeToggle;
      push_word(m, 4'($urandom()), 3'($urandom()), 3'($urandom()));
    end
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 16'd0;
    s_axis_tuser = ssf_pkg::ModeClear;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 4'd0;
    pwdata = 32'd0;
    display_reset();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // fill all eight digits, overflow by one, then toggle dots and scan past the wrap
    push_word(ssf_pkg::ModeClear, 4'd0, 3'd0, 3'd0);
    push_word(ssf_pkg::ModeAppend, 4'd8, 3'd7, 3'd7);
    push_word(ssf_pkg::ModeAppend, 4'd9, 3'd0, 3'd0);
    push_word(ssf_pkg::ModeAppend, 4'd15, 3'd0, 3'd0);
    push_word(ssf_pkg::ModeAppend, 4'd10, 3'd0, 3'd0);
    push_word(ssf_pkg::ModeAppend, 4'd0, 3'd0, 3'd0);
    push_word(ssf_pkg::ModeAppend, 4'd1, 3'd0, 3'd0);
    push_word(ssf_pkg::ModeAppend, 4'd2, 3'd0, 3'd0);
    push_word(ssf_pkg::ModeAppend, 4'd3, 3'd0, 3'd0);
    push_word(ssf_pkg::ModeAppend, 4'd7, 3'd0, 3'd0);
    push_word(ssf_pkg::ModeToggle, 4'd15, 3'd0, 3'd7);
    push_word(ssf_pkg::ModeToggle, 4'd0, 3'd6, 3'd2);
    push_word(ssf_pkg::ModeToggle, 4'd0, 3'd4, 3'd7);
    for (int k = 0; k < 9; k++) push_word(ssf_pkg::ModeTick, 4'hF, 3'd7, 3'd7);
    push_word(ssf_pkg::ModeClear, 4'hF, 3'd7, 3'd7);
    push_word(ssf_pkg::ModeTick, 4'd0, 3'd0, 3'd0);
    wait_drained();

    run_phase(4'd8, 3'd0, 3'd7, 16'd2, 0, 0, 170);
    run_phase(4'd1, 3'd0, 3'd0, 16'd1, 79, 0, 170);
    run_phase(4'd0, 3'd3, 3'd1, 16'd3, 0, 79, 170);
    run_phase(4'd15, 3'd2, 3'd5, 16'd4, 13, 13, 170);
    run_phase(4'd5, 3'd7, 3'd7, 16'hFFFF, 0, 0, 170);
    run_phase(4'd3, 3'd1, 3'd2, 16'd5, 79, 0, 170);
    run_phase(4'd7, 3'd0, 3'd6, 16'd0, 0, 79, 170);
    run_phase(4'd8, 3'd4, 3'd7, 16'd6, 13, 13, 170);

    $display("tb: %0d words accepted, %0d scan results compared, %0d register settings",
             taken_cnt, result_cnt, settings_cnt);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
